@@ rtl/ccss_pkg.sv @@
// Package for the CPU clock switch sequencer: command codes, register
// selects, masks and the controller/datapath command and status structs.
package ccss_pkg;

   localparam int TableDepthDefault = 16;
   localparam int DivLimitDefault   = 8;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_PRE  = 2'd1;
   localparam logic [1:0] KIND_POST = 2'd2;
   localparam logic [1:0] KIND_SET  = 2'd3;

   localparam logic [1:0] CMD_WRITE      = 2'd0;
   localparam logic [1:0] CMD_WAIT_ZERO  = 2'd1;
   localparam logic [1:0] CMD_WAIT_FIELD = 2'd2;

   localparam logic [2:0] REG_SRC    = 3'd0;
   localparam logic [2:0] REG_STAT   = 3'd1;
   localparam logic [2:0] REG_DIV0   = 3'd2;
   localparam logic [2:0] REG_DIV1   = 3'd3;
   localparam logic [2:0] REG_DSTAT0 = 3'd4;
   localparam logic [2:0] REG_DSTAT1 = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_SATURATED = 2'd2;

   localparam logic [31:0] RATIO0_MASK  = 32'h7;
   localparam logic [31:0] MUX_ALT_BIT  = 32'h0001_0000;
   localparam int          MUX_HPM_POS  = 20;
   localparam logic [31:0] HPM_DIV_MASK = 32'h77;

   // Which value a write command carries.
   typedef enum logic [2:0] {
      VAL_ZERO     = 3'd0,
      VAL_SAFE_DIV0 = 3'd1,
      VAL_SRC_ALT  = 3'd2,
      VAL_SRC_MAIN = 3'd3,
      VAL_DIV0     = 3'd4,
      VAL_DIV1     = 3'd5,
      VAL_DIV0_CLR = 3'd6
   } val_sel_type;

   // Controller to datapath.
   typedef struct packed {
      logic        capture;     // latch the accepted word
      logic        search_start;
      logic        search_step;
      logic        div_start;
      logic        load_row;
      logic        emit;        // load the output register
      logic [1:0]  cmd_kind;
      logic [2:0]  reg_select;
      val_sel_type val_sel;
      logic [2:0]  field_value;
      logic        not_found;   // emit the not-found word
      logic        last;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       search_done;
      logic       found;
      logic       div_done;
      logic       need_safe;
      logic       out_busy;
   } dp_stat_type;

endpackage

@@ rtl/ccss_datapath.sv @@
// Datapath of the CPU clock switch sequencer: row table, search counter,
// restoring divider for the safe divider and the output register.
// Depends on ccss_pkg.
module ccss_datapath #(
   parameter int TABLE_DEPTH = ccss_pkg::TableDepthDefault,
   parameter int DIV_LIMIT   = ccss_pkg::DivLimitDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           in_kind,
   input  logic [3:0]           in_row_index,
   input  logic [31:0]          in_row_rate,
   input  logic [27:0]          in_row_div0,
   input  logic [11:0]          in_row_div1,
   input  logic [31:0]          in_target_rate,
   input  logic [31:0]          in_present_rate,
   input  logic [31:0]          in_alt_rate,
   input  logic [31:0]          in_cur_src,
   input  logic [31:0]          in_cur_div0,
   input  logic [31:0]          in_cur_div1,
   input  ccss_pkg::ctl_cmd_type cmd,
   output ccss_pkg::dp_stat_type stat,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [1:0]           out_cmd_kind,
   output logic [2:0]           out_reg_select,
   output logic [31:0]          out_write_value,
   output logic [2:0]           out_wait_field_value,
   output logic [1:0]           out_status,
   output logic                 out_last
);
   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   // Captured item
   logic [1:0]  kind_ff;
   logic [31:0] target_rate_ff, present_rate_ff, alt_rate_ff, src_ff, div0c_ff, div1c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= ccss_pkg::KIND_LOAD;
      end else if (cmd.capture) begin
         kind_ff <= in_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         target_rate_ff  <= in_target_rate;
         present_rate_ff <= in_present_rate;
         alt_rate_ff     <= in_alt_rate;
         src_ff          <= in_cur_src;
         div0c_ff        <= in_cur_div0;
         div1c_ff        <= in_cur_div1;
      end
   end

   // Row table; rates have valid bits so reset reads as terminator
   logic [31:0] rate_mem [TABLE_DEPTH];
   logic [27:0] diva_mem [TABLE_DEPTH];
   logic [11:0] divb_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic        row_ok;
   logic [IdxW-1:0] widx;

   assign row_ok = ({28'd0, in_row_index} < 32'(TABLE_DEPTH));
   assign widx   = IdxW'(in_row_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.load_row && row_ok) begin
         valid_ff[widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row && row_ok) begin
         rate_mem[widx] <= in_row_rate;
         diva_mem[widx] <= in_row_div0;
         divb_mem[widx] <= in_row_div1;
      end
   end

   // Search: one registered row read per step
   logic [CntW-1:0] sidx_ff;
   logic [31:0] rd_rate_ff;
   logic [27:0] rd_diva_ff;
   logic [11:0] rd_divb_ff;
   logic        rd_valid_ff, rd_pend_ff, sdone_ff, found_ff;
   logic [27:0] hit_diva_ff;
   logic [11:0] hit_divb_ff;

   always_ff @(posedge clock) begin
      if (sidx_ff < CntW'(TABLE_DEPTH)) begin
         rd_rate_ff <= rate_mem[sidx_ff[IdxW-1:0]];
         rd_diva_ff <= diva_mem[sidx_ff[IdxW-1:0]];
         rd_divb_ff <= divb_mem[sidx_ff[IdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sidx_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
         sdone_ff    <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.search_start) begin
         sidx_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         sdone_ff    <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.search_step && !sdone_ff) begin
         if (!rd_pend_ff) begin
            // issue read of current row
            if (sidx_ff >= CntW'(TABLE_DEPTH)) begin
               sdone_ff <= 1'b1;
            end else begin
               rd_valid_ff <= valid_ff[sidx_ff[IdxW-1:0]];
               rd_pend_ff  <= 1'b1;
            end
         end else begin
            rd_pend_ff <= 1'b0;
            if (!rd_valid_ff || rd_rate_ff == 32'd0) begin
               sdone_ff <= 1'b1;
            end else if (rd_rate_ff == target_rate_ff) begin
               sdone_ff <= 1'b1;
               found_ff <= 1'b1;
            end else begin
               sidx_ff <= sidx_ff + CntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_step && rd_pend_ff) begin
         hit_diva_ff <= rd_diva_ff;
         hit_divb_ff <= rd_divb_ff;
      end
   end

   // Restoring divider: (alt-1)/old, one quotient bit per cycle
   logic [31:0] quo_ff, rem_ff, dvd_ff;
   logic [5:0]  dcnt_ff;
   logic        dbusy_ff, ddone_ff;
   logic [32:0] trial;

   assign trial = {rem_ff, dvd_ff[31]} - {1'b0, present_rate_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         ddone_ff <= 1'b0;
         dcnt_ff  <= 6'd32;
      end else if (dbusy_ff) begin
         dcnt_ff <= dcnt_ff - 6'd1;
         if (dcnt_ff == 6'd1) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff <= alt_rate_ff - 32'd1;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (dbusy_ff) begin
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], dvd_ff[31]};
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
      end
   end

   logic        need_safe, sat;
   logic [2:0]  sd;
   logic [1:0]  run_status;
   assign need_safe = alt_rate_ff > present_rate_ff;
   assign sat = (present_rate_ff == 32'd0) || (quo_ff >= 32'(DIV_LIMIT));
   assign sd  = sat ? 3'(DIV_LIMIT - 1) : quo_ff[2:0];
   assign run_status = (need_safe && sat) ? ccss_pkg::ST_SATURATED : ccss_pkg::ST_OK;

   // Write values
   logic [31:0] div0_val, div1_val, row_div1;
   assign row_div1 = {20'd0, hit_divb_ff};
   assign div0_val = {4'd0, hit_diva_ff} | (need_safe ? {29'd0, sd} : 32'd0);
   assign div1_val = src_ff[ccss_pkg::MUX_HPM_POS]
      ? ((div1c_ff & ccss_pkg::HPM_DIV_MASK) | (row_div1 & ~ccss_pkg::HPM_DIV_MASK))
      : row_div1;

   logic [31:0] val;
   always_comb begin
      unique case (cmd.val_sel)
         ccss_pkg::VAL_SAFE_DIV0: val = (div0c_ff & ~ccss_pkg::RATIO0_MASK) | {29'd0, sd};
         ccss_pkg::VAL_SRC_ALT:   val = src_ff | ccss_pkg::MUX_ALT_BIT;
         ccss_pkg::VAL_SRC_MAIN:  val = src_ff & ~ccss_pkg::MUX_ALT_BIT;
         ccss_pkg::VAL_DIV0:      val = div0_val;
         ccss_pkg::VAL_DIV1:      val = div1_val;
         ccss_pkg::VAL_DIV0_CLR:  val = div0c_ff & ~ccss_pkg::RATIO0_MASK;
         default:                 val = 32'd0;
      endcase
   end

   // Output register
   logic        ovalid_ff;
   logic [1:0]  okind_ff, ost_ff;
   logic [2:0]  oreg_ff, ofld_ff;
   logic [31:0] oval_ff;
   logic        olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.emit) begin
         ovalid_ff <= 1'b1;
      end else if (out_ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         okind_ff <= cmd.cmd_kind;
         oreg_ff  <= cmd.reg_select;
         oval_ff  <= val;
         ofld_ff  <= cmd.field_value;
         olast_ff <= cmd.last;
         if (cmd.not_found) begin
            ost_ff <= ccss_pkg::ST_NOT_FOUND;
         end else if (kind_ff == ccss_pkg::KIND_PRE) begin
            ost_ff <= run_status;
         end else begin
            ost_ff <= ccss_pkg::ST_OK;
         end
      end
   end

   assign out_valid            = ovalid_ff;
   assign out_cmd_kind         = okind_ff;
   assign out_reg_select       = oreg_ff;
   assign out_write_value      = oval_ff;
   assign out_wait_field_value = ofld_ff;
   assign out_status           = ost_ff;
   assign out_last             = olast_ff;

   assign stat.kind        = kind_ff;
   assign stat.search_done = sdone_ff;
   assign stat.found       = found_ff;
   assign stat.div_done    = ddone_ff;
   assign stat.need_safe   = need_safe;
   assign stat.out_busy    = ovalid_ff && !out_ready;
endmodule

@@ rtl/ccss_controller.sv @@
// Controller of the CPU clock switch sequencer: accepts words, steps the
// search and divider, and issues the command sequence. Depends on ccss_pkg.
module ccss_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            in_kind,
   input  ccss_pkg::dp_stat_type stat,
   output ccss_pkg::ctl_cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SEARCH = 5'b00010,
      S_DIV    = 5'b00100,
      S_EMIT   = 5'b01000,
      S_DIVGO  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   assign in_ready = (state_ff == S_IDLE);

   // Command for current step of the run
   typedef struct packed {
      logic [1:0]            kind;
      logic [2:0]            rsel;
      ccss_pkg::val_sel_type vsel;
      logic [2:0]            fld;
      logic                  nf;
      logic                  last;
      logic [2:0]            next;
   } entry_type;

   entry_type e;

   always_comb begin
      e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC, ccss_pkg::VAL_ZERO, 3'd0, 1'b0,
             1'b0, 3'd0};
      if (stat.kind == ccss_pkg::KIND_POST) begin
         if (step_ff == 3'd0) begin
            e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC, ccss_pkg::VAL_SRC_MAIN,
                  3'd0, 1'b0, 1'b0, 3'd1};
         end else begin
            e = '{ccss_pkg::CMD_WAIT_FIELD, ccss_pkg::REG_STAT, ccss_pkg::VAL_ZERO,
                  3'd1, 1'b0, 1'b1, 3'd0};
         end
      end else if (stat.kind == ccss_pkg::KIND_SET) begin
         if (step_ff == 3'd0) begin
            e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0, ccss_pkg::VAL_DIV0_CLR,
                  3'd0, 1'b0, 1'b0, 3'd1};
         end else begin
            e = '{ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0, ccss_pkg::VAL_ZERO,
                  3'd0, 1'b0, 1'b1, 3'd0};
         end
      end else if (!stat.found) begin
         e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC, ccss_pkg::VAL_ZERO, 3'd0,
               1'b1, 1'b1, 3'd0};
      end else begin
         unique case (step_ff)
            3'd0: e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0,
                        ccss_pkg::VAL_SAFE_DIV0, 3'd0, 1'b0, 1'b0, 3'd1};
            3'd1: e = '{ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0,
                        ccss_pkg::VAL_ZERO, 3'd0, 1'b0, 1'b0, 3'd2};
            3'd2: e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC,
                        ccss_pkg::VAL_SRC_ALT, 3'd0, 1'b0, 1'b0, 3'd3};
            3'd3: e = '{ccss_pkg::CMD_WAIT_FIELD, ccss_pkg::REG_STAT,
                        ccss_pkg::VAL_ZERO, 3'd2, 1'b0, 1'b0, 3'd4};
            3'd4: e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0,
                        ccss_pkg::VAL_DIV0, 3'd0, 1'b0, 1'b0, 3'd5};
            3'd5: e = '{ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0,
                        ccss_pkg::VAL_ZERO, 3'd0, 1'b0, 1'b0, 3'd6};
            3'd6: e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV1,
                        ccss_pkg::VAL_DIV1, 3'd0, 1'b0, 1'b0, 3'd7};
            3'd7: e = '{ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT1,
                        ccss_pkg::VAL_ZERO, 3'd0, 1'b0, 1'b1, 3'd0};
            default: e = '{ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC,
                        ccss_pkg::VAL_ZERO, 3'd0, 1'b0, 1'b0, 3'd0};
         endcase
      end
   end

   // Advance state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.cmd_kind    = e.kind;
      cmd.reg_select  = e.rsel;
      cmd.val_sel     = e.vsel;
      cmd.field_value = e.fld;
      cmd.not_found   = e.nf;
      cmd.last        = e.last;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.capture = 1'b1;
               step_in     = 3'd0;
               unique case (in_kind)
                  ccss_pkg::KIND_LOAD: cmd.load_row = 1'b1;
                  ccss_pkg::KIND_PRE: begin
                     cmd.search_start = 1'b1;
                     state_in = S_SEARCH;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.search_done) begin
               cmd.search_step = 1'b0;
               if (stat.found && stat.need_safe) begin
                  state_in = S_DIVGO;
               end else begin
                  state_in = S_EMIT;
                  step_in  = (stat.found) ? 3'd2 : 3'd0;
               end
            end
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               state_in = S_EMIT;
               step_in  = 3'd0;
            end
         end
         S_EMIT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               step_in  = e.next;
               if (e.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end
endmodule

@@ rtl/cpu_clock_switch_sequencer.sv @@
// Channel | direction | tdata fields (low bit up)                          | tuser
// req     | in        | row_index,row_rate,row_div0,row_div1,target_rate,   | kind
//         |           | present_rate,alt_rate,cur_src,cur_div0,cur_div1 (268b)|
// rsp     | out       | reg_select,write_value,wait_field_value,status (40b)| cmd_kind; tlast=last
// Load words write one table row. A pre-change word searches the table one row
// at a time with a registered read per row, then, when the alternate rate is higher,
// runs a restoring divider (start, 32 steps, done), then emits up to 8 words,
// one per cycle when rsp_tready is high. Post and set-rate words emit two words.
// A new word is taken only once the run is fully issued; rsp stalls hold the
// controller.
// Reset is synchronous and clears the table valid bits and control state.
// Depends on ccss_pkg, ccss_controller, ccss_datapath.
module cpu_clock_switch_sequencer #(
   parameter int TABLE_DEPTH = ccss_pkg::TableDepthDefault,
   parameter int DIV_LIMIT   = ccss_pkg::DivLimitDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [271:0] req_tdata,  // row_index, row_rate, row_div0, row_div1, target_rate,
                                    // present_rate, alt_rate, cur_src, cur_div0, cur_div1
   input  logic [1:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // reg_select, write_value, wait_field_value, status
   output logic [1:0]   rsp_tuser,  // cmd_kind
   output logic         rsp_tlast
);
   ccss_pkg::ctl_cmd_type cmd;
   ccss_pkg::dp_stat_type stat;
   logic [2:0]  rsel, fld;
   logic [31:0] wval;
   logic [1:0]  st;

   ccss_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .stat     (stat),
      .cmd      (cmd)
   );

   ccss_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .DIV_LIMIT(DIV_LIMIT)) u_dp (
      .clock                (clock),
      .reset                (reset),
      .in_kind              (req_tuser),
      .in_row_index         (req_tdata[3:0]),
      .in_row_rate          (req_tdata[35:4]),
      .in_row_div0          (req_tdata[63:36]),
      .in_row_div1          (req_tdata[75:64]),
      .in_target_rate       (req_tdata[107:76]),
      .in_present_rate      (req_tdata[139:108]),
      .in_alt_rate          (req_tdata[171:140]),
      .in_cur_src           (req_tdata[203:172]),
      .in_cur_div0          (req_tdata[235:204]),
      .in_cur_div1          (req_tdata[267:236]),
      .cmd                  (cmd),
      .stat                 (stat),
      .out_valid            (rsp_tvalid),
      .out_ready            (rsp_tready),
      .out_cmd_kind         (rsp_tuser),
      .out_reg_select       (rsel),
      .out_write_value      (wval),
      .out_wait_field_value (fld),
      .out_status           (st),
      .out_last             (rsp_tlast)
   );

   assign rsp_tdata = {st, fld, wval, rsel};

`ifndef SYNTHESIS
   // A stalled result stays put until it is taken.
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");
   // Not-found result is always the last of its run.
   a_nf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[39:38] == ccss_pkg::ST_NOT_FOUND) |-> rsp_tlast)
      else $error("not-found result without last");
`endif
endmodule

@@ bench/cpu_clock_switch_sequencer_tb.sv @@
// Self-checking bench for the CPU clock switch sequencer: drives request words,
// predicts each command run and compares it on the response stream.
// Depends on ccss_pkg and cpu_clock_switch_sequencer.
`timescale 1ns / 100ps

module cpu_clock_switch_sequencer_tb;

   localparam int DEPTH = ccss_pkg::TableDepthDefault;
   localparam int LIMIT = ccss_pkg::DivLimitDefault;

   typedef struct packed {
      logic [1:0]  cmd_kind;
      logic [2:0]  reg_select;
      logic [31:0] write_value;
      logic [2:0]  field_value;
      logic [1:0]  status;
      logic        last;
   } cmd_word_type;

   typedef struct {
      logic [1:0]  kind;
      logic [3:0]  row_index;
      logic [31:0] row_rate;
      logic [27:0] row_div0;
      logic [11:0] row_div1;
      logic [31:0] target_rate;
      logic [31:0] present_rate;
      logic [31:0] alt_rate;
      logic [31:0] cur_src;
      logic [31:0] cur_div0;
      logic [31:0] cur_div1;
   } request_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [271:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;

   // predictor copy of the rate table
   logic [31:0]   rate_table [DEPTH];
   logic [27:0]   div0_table [DEPTH];
   logic [11:0]   div1_table [DEPTH];

   cmd_word_type  pending_cmds [$];
   int            error_count = 0;
   bit            stall_on = 1'b1;

   always #4 clock = ~clock;

   cpu_clock_switch_sequencer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic cmd_word_type make_cmd(logic [1:0] k, logic [2:0] r,
                                             logic [31:0] v, logic [2:0] f,
                                             logic [1:0] s);
      cmd_word_type c;
      c.cmd_kind = k; c.reg_select = r; c.write_value = v;
      c.field_value = f; c.status = s; c.last = 1'b0;
      return c;
   endfunction

   // compute the command run of one request and update the table
   task automatic predict_switch_run(input request_type q);
      cmd_word_type run [$];
      int           hit;
      logic [1:0]   st;
      logic [31:0]  div0, div1, sd;
      hit = -1;
      st = ccss_pkg::ST_OK;
      case (q.kind)
         ccss_pkg::KIND_LOAD: begin
            rate_table[q.row_index] = q.row_rate;
            div0_table[q.row_index] = q.row_div0;
            div1_table[q.row_index] = q.row_div1;
         end
         ccss_pkg::KIND_PRE: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (rate_table[i] == 0) break;
               if (rate_table[i] == q.target_rate) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) begin
               run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC, 32'd0, 3'd0,
                                      ccss_pkg::ST_NOT_FOUND));
            end else begin
               div0 = {4'b0, div0_table[hit]};
               div1 = {20'b0, div1_table[hit]};
               if (q.cur_src[ccss_pkg::MUX_HPM_POS])
                  div1 = (q.cur_div1 & ccss_pkg::HPM_DIV_MASK)
                         | (div1 & ~ccss_pkg::HPM_DIV_MASK);
               if (q.alt_rate > q.present_rate) begin
                  if (q.present_rate == 0) begin
                     sd = 32'(LIMIT - 1);
                     st = ccss_pkg::ST_SATURATED;
                  end else begin
                     sd = (q.alt_rate - 32'd1) / q.present_rate;
                     if (sd >= 32'(LIMIT)) begin
                        sd = 32'(LIMIT - 1);
                        st = ccss_pkg::ST_SATURATED;
                     end
                  end
                  sd &= ccss_pkg::RATIO0_MASK;
                  run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0,
                                         (q.cur_div0 & ~ccss_pkg::RATIO0_MASK) | sd,
                                         3'd0, st));
                  run.push_back(make_cmd(ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0,
                                         32'd0, 3'd0, st));
                  div0 |= sd;
               end
               run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC,
                                      q.cur_src | ccss_pkg::MUX_ALT_BIT, 3'd0, st));
               run.push_back(make_cmd(ccss_pkg::CMD_WAIT_FIELD, ccss_pkg::REG_STAT,
                                      32'd0, 3'd2, st));
               run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0,
                                      div0, 3'd0, st));
               run.push_back(make_cmd(ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0,
                                      32'd0, 3'd0, st));
               run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV1,
                                      div1, 3'd0, st));
               run.push_back(make_cmd(ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT1,
                                      32'd0, 3'd0, st));
            end
         end
         ccss_pkg::KIND_POST: begin
            run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_SRC,
                                   q.cur_src & ~ccss_pkg::MUX_ALT_BIT, 3'd0,
                                   ccss_pkg::ST_OK));
            run.push_back(make_cmd(ccss_pkg::CMD_WAIT_FIELD, ccss_pkg::REG_STAT,
                                   32'd0, 3'd1, ccss_pkg::ST_OK));
         end
         default: begin
            run.push_back(make_cmd(ccss_pkg::CMD_WRITE, ccss_pkg::REG_DIV0,
                                   q.cur_div0 & ~ccss_pkg::RATIO0_MASK, 3'd0,
                                   ccss_pkg::ST_OK));
            run.push_back(make_cmd(ccss_pkg::CMD_WAIT_ZERO, ccss_pkg::REG_DSTAT0,
                                   32'd0, 3'd0, ccss_pkg::ST_OK));
         end
      endcase
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) pending_cmds.push_back(run[i]);
   endtask

   // drive one word and hold it until accepted; predict on acceptance
   task automatic send_word(input request_type q);
      req_tuser <= q.kind;
      req_tdata <= {4'b0, q.cur_div1, q.cur_div0, q.cur_src, q.alt_rate, q.present_rate,
                    q.target_rate, q.row_div1, q.row_div0, q.row_rate, q.row_index};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_switch_run(q);
      @(negedge clock);
   endtask

   // random gap between bursts
   int burst_left = 0;
   task automatic send_paced(input request_type q);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      send_word(q);
   endtask

   // drop valid and hold until every expected command is out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() > 0) @(negedge clock);
   endtask

   function automatic request_type blank_req(logic [1:0] k);
      request_type q;
      q.kind = k;
      q.row_index = 4'($urandom); q.row_rate = $urandom; q.row_div0 = 28'($urandom);
      q.row_div1 = 12'($urandom); q.target_rate = $urandom; q.present_rate = $urandom;
      q.alt_rate = $urandom; q.cur_src = $urandom; q.cur_div0 = $urandom;
      q.cur_div1 = $urandom;
      return q;
   endfunction

   function automatic request_type load_req(int idx, logic [31:0] rate);
      request_type q;
      q = blank_req(ccss_pkg::KIND_LOAD);
      q.row_index = 4'(idx);
      q.row_rate = rate;
      return q;
   endfunction

   function automatic request_type pre_req(logic [31:0] nr, logic [31:0 ] oldr,
                                           logic [31:0] altr);
      request_type q;
      q = blank_req(ccss_pkg::KIND_PRE);
      q.target_rate = nr; q.present_rate = oldr; q.alt_rate = altr;
      return q;
   endfunction

   // lookups on an empty table, then the two non-table kinds
   task automatic test_empty_table();
      send_paced(pre_req(32'd100, 1, 2));
      send_paced(pre_req(32'd0, 1, 0));
      send_paced(blank_req(ccss_pkg::KIND_POST));
      send_paced(blank_req(ccss_pkg::KIND_SET));
   endtask

   // fill rows, then hit, miss, divider edge cases and HPM mux
   task automatic test_directed_switch();
      request_type q;
      send_paced(load_req(0, 32'd1000));
      send_paced(load_req(1, 32'hFFFF_FFFF));
      q = load_req(2, 32'd5);
      q.row_div0 = 28'hFFF_FFFF; q.row_div1 = 12'hFFF;
      send_paced(q);
      q = load_req(3, 32'd7);
      q.row_div0 = '0; q.row_div1 = '0;
      send_paced(q);
      send_paced(pre_req(32'd1000, 100, 50));        // alt slower: no safe div
      send_paced(pre_req(32'hFFFF_FFFF, 100, 100));  // equal rates
      send_paced(pre_req(32'd5, 100, 101));          // divider 1
      send_paced(pre_req(32'd5, 100, 800));          // divider 7
      send_paced(pre_req(32'd7, 100, 801));          // saturates
      send_paced(pre_req(32'd7, 0, 1));              // old rate zero
      send_paced(pre_req(32'd7, 1, 32'hFFFF_FFFF));
      send_paced(pre_req(32'd9, 1, 2));              // not in table
      q = pre_req(32'd5, 3, 2);
      q.cur_src = 32'h0010_0000; q.cur_div1 = 32'hFFFF_FFFF;
      send_paced(q);                                 // HPM mux set
      q.cur_src = 32'hFFEF_FFFF;
      send_paced(q);
      q = blank_req(ccss_pkg::KIND_POST); q.cur_src = 32'hFFFF_FFFF; send_paced(q);
      q = blank_req(ccss_pkg::KIND_SET); q.cur_div0 = 32'hFFFF_FFFF; send_paced(q);
      // zero row truncates the table before later rows
      send_paced(load_req(1, 32'd0));
      send_paced(pre_req(32'd5, 10, 5));
      send_paced(load_req(1, 32'hFFFF_FFFF));
      wait_drained();
   endtask

   // random mix: half lookups, mostly of loaded rates, with random rates around them
   task automatic test_random_mix();
      request_type q;
      int n;
      for (int i = 0; i < 250; i++) begin
         n = $urandom_range(0, 99);
         if (n < 20) begin
            q = load_req($urandom_range(0, DEPTH - 1), $urandom);
            if ($urandom_range(0, 9) == 0) q.row_rate = 0;
         end else if (n < 70) begin
            q = blank_req(ccss_pkg::KIND_PRE);
            if ($urandom_range(0, 4) != 0)
               q.target_rate = rate_table[$urandom_range(0, DEPTH - 1)];
            if ($urandom_range(0, 1)) q.present_rate = $urandom_range(1, 1000);
            if ($urandom_range(0, 1)) q.alt_rate = $urandom_range(0, 9000);
            if ($urandom_range(0, 9) == 0) q.present_rate = 0;
         end else if (n < 85) q = blank_req(ccss_pkg::KIND_POST);
         else q = blank_req(ccss_pkg::KIND_SET);
         send_paced(q);
         // one pause until all commands are out
         if (i == 120) wait_drained();
      end
   endtask

   // response stall pattern: long ready stretches and stall bursts
   always @(negedge clock) begin
      if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
      rsp_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   // compare each accepted command with the oldest expectation
   always @(posedge clock) begin
      cmd_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("unexpected command", rsp_tdata[34:3], 32'd0);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_tuser !== want.cmd_kind)
               report_mismatch("cmd_kind", 32'(rsp_tuser), 32'(want.cmd_kind));
            if (rsp_tdata[2:0] !== want.reg_select)
               report_mismatch("reg_select", 32'(rsp_tdata[2:0]), 32'(want.reg_select));
            if (rsp_tdata[34:3] !== want.write_value)
               report_mismatch("write_value", rsp_tdata[34:3], want.write_value);
            if (rsp_tdata[37:35] !== want.field_value)
               report_mismatch("wait_field_value", 32'(rsp_tdata[37:35]),
                               32'(want.field_value));
            if (rsp_tdata[39:38] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[39:38]), 32'(want.status));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         rate_table[i] = '0; div0_table[i] = '0; div1_table[i] = '0;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_switch();
      test_random_mix();
      wait_drained();
      repeat (100) @(negedge clock);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
